>>> sv/vprd_pkg.sv
// Shared constants, codes and types for the valve position ramp drive.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package vprd_pkg;

	// Field widths.
	localparam int SAMPLE_BITS = 10;
	localparam int POS_W       = 7;
	localparam int DUTY_W      = 8;
	localparam int MS_W        = 16;
	localparam int CFG_W       = 16;
	localparam int IDX_W       = 3;
	localparam int CMD_W       = 2;
	localparam int NUM_W       = SAMPLE_BITS + POS_W;

	// Item commands.
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_CAL_MIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CAL_MAX   = 3'd1;
	localparam logic [IDX_W-1:0] REG_RAMP_STEP = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEADBAND  = 3'd3;
	localparam logic [IDX_W-1:0] REG_IDLE_MS   = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOCKOUT   = 3'd5;
	localparam logic [IDX_W-1:0] REG_FORCE_MS  = 3'd6;

	// Register reset values.
	localparam logic [SAMPLE_BITS-1:0] CAL_MIN_RST  = '0;
	localparam logic [SAMPLE_BITS-1:0] CAL_MAX_RST  = SAMPLE_BITS'(1023);
	localparam logic [POS_W-1:0]       RAMP_RST     = 7'd5;
	localparam logic [POS_W-1:0]       DEADBAND_RST = 7'd2;
	localparam logic [MS_W-1:0]        IDLE_RST     = 16'd500;
	localparam logic [MS_W-1:0]        LOCKOUT_RST  = 16'd5000;
	localparam logic [MS_W-1:0]        FORCE_RST    = 16'd2000;

	// Position and duty constants.
	localparam logic [POS_W-1:0]  POS_MAX   = 7'd100;
	localparam logic [POS_W-1:0]  EDGE_LO   = 7'd20;
	localparam logic [POS_W-1:0]  EDGE_HI   = 7'd80;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
	localparam logic [DUTY_W-1:0] DUTY_BIAS = 8'd50;
	localparam logic [MS_W-1:0]   MS_SAT    = 16'hFFFF;
	localparam logic [NUM_W-1:0]  PCT_SCALE = NUM_W'(100);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY
	} vprd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic apply;
	} vprd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic out_free;
	} vprd_status_t;

endpackage

>>> sv/valve_position_ramp_drive_core.sv
// Top level of the valve position ramp drive: controller plus datapath.
// Depends on vprd_pkg, vprd_ctrl, vprd_dp and vprd_div.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall     cmd, pot_sample
//   result    result_valid / result_stall open_duty, close_duty, position, target, locked
//   config    cfg_we                      cfg_index, cfg_data
//
// Every word holds the block until it commits: the accepting edge takes the word and
// starts the divider, the restoring divider scales the pot sample one quotient bit
// at a time, the controller sees it finish and then commits the new valve state,
// which makes the result valid, and only after that commit is the next word taken.
// Ticks and button presses run the same path.
// Reset clears the valve state, loads the register defaults and sets the idle
// counter to its saturated value. A result waits in the output register while
// the next word is accepted and divided; the commit waits only if that
// register is still held by a stalled consumer.
`timescale 1ns / 1ps

module valve_position_ramp_drive_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vprd_pkg::IDX_W-1:0]       cfg_index,
	input  logic [vprd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [vprd_pkg::CMD_W-1:0]       cmd,
	input  logic [vprd_pkg::SAMPLE_BITS-1:0] pot_sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [vprd_pkg::DUTY_W-1:0]      open_duty,
	output logic [vprd_pkg::DUTY_W-1:0]      close_duty,
	output logic [vprd_pkg::POS_W-1:0]       position,
	output logic [vprd_pkg::POS_W-1:0]       target,
	output logic                             locked
);
	import vprd_pkg::*;

	// Commands and status between the controller and the datapath.
	vprd_cmd_t    ctl;
	vprd_status_t sts;

	// The controller owns the input handshake and sequences each word.
	vprd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.ctl        (ctl)
	);

	// The datapath holds the registers, the valve state and the result register.
	vprd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.pot_sample   (pot_sample),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.open_duty    (open_duty),
		.close_duty   (close_duty),
		.position     (position),
		.target       (target),
		.locked       (locked)
	);

endmodule

>>> sv/vprd_div.sv
// Restoring divider for the calibrated raw position, one quotient bit per cycle.
// Depends on vprd_pkg.
`timescale 1ns / 1ps

module vprd_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [vprd_pkg::NUM_W-1:0]       num,
	input  logic [vprd_pkg::SAMPLE_BITS-1:0] den,
	output logic                             busy,
	output logic [vprd_pkg::POS_W-1:0]       quot
);
	import vprd_pkg::*;

	logic                   busy_q;
	logic [NUM_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [2:0]             bit_q;
	logic [POS_W-1:0]       quot_q;
	logic [NUM_W-1:0]       trial;

	// With a valid calibration the quotient never exceeds 100, so seven shifted subtractions cover it.
	assign trial = {{POS_W{1'b0}}, den_q} << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (bit_q == 3'd0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			bit_q  <= 3'(POS_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q         <= rem_q - trial;
				quot_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

>>> sv/vprd_dp.sv
// Datapath: configuration registers, valve state, divider and result register.
// Depends on vprd_pkg and vprd_div.
`timescale 1ns / 1ps

module vprd_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [vprd_pkg::IDX_W-1:0]       cfg_index,
	input  logic [vprd_pkg::CFG_W-1:0]       cfg_data,
	input  logic [vprd_pkg::CMD_W-1:0]       cmd,
	input  logic [vprd_pkg::SAMPLE_BITS-1:0] pot_sample,
	input  vprd_pkg::vprd_cmd_t              ctl,
	output vprd_pkg::vprd_status_t           sts,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [vprd_pkg::DUTY_W-1:0]      open_duty,
	output logic [vprd_pkg::DUTY_W-1:0]      close_duty,
	output logic [vprd_pkg::POS_W-1:0]       position,
	output logic [vprd_pkg::POS_W-1:0]       target,
	output logic                             locked
);
	import vprd_pkg::*;

	// Maps raw 20..80 onto 0..100: (raw - 20) * 5 / 3, the divide by three
	// done as a multiply by 683 / 2048, exact for the values that reach it.
	function automatic logic [POS_W-1:0] target_of(input logic [POS_W-1:0] raw);
		logic [POS_W-1:0] span;
		logic [8:0]       span5;
		logic [18:0]      prod;
		span  = raw - EDGE_LO;
		span5 = {2'b00, span} * 9'd5;
		prod  = {10'b0, span5} * 19'd683;
		if (raw < EDGE_LO) begin
			return '0;
		end else if (raw > EDGE_HI) begin
			return POS_MAX;
		end else begin
			return prod[17:11];
		end
	endfunction

	// Configuration.
	logic [SAMPLE_BITS-1:0] cal_min_q, cal_max_q;
	logic [POS_W-1:0]       ramp_q, deadband_q;
	logic [MS_W-1:0]        idle_ms_q, lockout_ms_q, force_ms_q;

	// Valve state.
	logic [POS_W-1:0]       cur_q, target_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [DUTY_W-1:0]      open_q, close_q;
	logic [MS_W-1:0]        idle_q, lock_q, force_q;

	// Held item.
	logic [CMD_W-1:0]       cmd_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	// Result register.
	logic                   rvalid_q;
	logic [DUTY_W-1:0]      r_open_q, r_close_q;
	logic [POS_W-1:0]       r_pos_q, r_target_q;
	logic                   r_locked_q;

	// Divider hookup.
	logic [SAMPLE_BITS-1:0] clamp_lo, clamp_x;
	logic [NUM_W-1:0]       num;
	logic [SAMPLE_BITS-1:0] den;
	logic                   div_busy;
	logic [POS_W-1:0]       quot;

	// Next state.
	logic                   cal_ok, locked_now, move, up, down, rising, falling;
	logic [POS_W-1:0]       raw, t, c, diff, c_dn, c_new;
	logic [POS_W:0]         c_upw;
	logic [DUTY_W-1:0]      bias;
	logic [POS_W-1:0]       nxt_cur, nxt_target;
	logic [SAMPLE_BITS-1:0] nxt_prev;
	logic [DUTY_W-1:0]      nxt_open, nxt_close;
	logic [MS_W-1:0]        nxt_idle, nxt_lock, nxt_force;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q    <= CAL_MIN_RST;
			cal_max_q    <= CAL_MAX_RST;
			ramp_q       <= RAMP_RST;
			deadband_q   <= DEADBAND_RST;
			idle_ms_q    <= IDLE_RST;
			lockout_ms_q <= LOCKOUT_RST;
			force_ms_q   <= FORCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_MIN:   cal_min_q    <= cfg_data[SAMPLE_BITS-1:0];
				REG_CAL_MAX:   cal_max_q    <= cfg_data[SAMPLE_BITS-1:0];
				REG_RAMP_STEP: ramp_q       <= cfg_data[POS_W-1:0];
				REG_DEADBAND:  deadband_q   <= cfg_data[POS_W-1:0];
				REG_IDLE_MS:   idle_ms_q    <= cfg_data[MS_W-1:0];
				REG_LOCKOUT:   lockout_ms_q <= cfg_data[MS_W-1:0];
				REG_FORCE_MS:  force_ms_q   <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// The numerator is formed from the incoming sample so the divider starts
	// at the edge that takes the word.
	assign clamp_lo = (pot_sample < cal_min_q) ? cal_min_q : pot_sample;
	assign clamp_x  = (clamp_lo > cal_max_q) ? cal_max_q : clamp_lo;
	assign num      = {{POS_W{1'b0}}, clamp_x - cal_min_q} * PCT_SCALE;
	assign den      = cal_max_q - cal_min_q;

	vprd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.load),
		.num    (num),
		.den    (den),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			sample_q <= pot_sample;
		end
	end

	always_comb begin
		cal_ok     = cal_max_q > cal_min_q;
		locked_now = (force_q != '0) || (lock_q != '0);
		raw        = cal_ok ? quot : '0;
		t          = target_of(raw);
		c          = cur_q;
		up         = t > c;
		down       = t < c;
		diff       = up ? (t - c) : (c - t);
		move       = (diff > deadband_q) || ((t == '0) && (c != '0)) ||
		             ((t == POS_MAX) && (c < POS_MAX));
		rising     = sample_q > prev_q;
		falling    = sample_q < prev_q;
		bias       = {1'b0, diff} + DUTY_BIAS;
		c_upw      = {1'b0, c} + {1'b0, ramp_q};
		c_dn       = (c > ramp_q) ? (c - ramp_q) : '0;
		c_new      = c;

		nxt_cur    = cur_q;
		nxt_target = target_q;
		nxt_prev   = prev_q;
		nxt_open   = open_q;
		nxt_close  = close_q;
		nxt_idle   = idle_q;
		nxt_lock   = lock_q;
		nxt_force  = force_q;

		case (cmd_q)
			CMD_SAMPLE: begin
				if (!locked_now) begin
					nxt_target = t;
					nxt_prev   = sample_q;
					if (move) begin
						nxt_idle = '0;
						if (up) begin
							nxt_open  = (raw > EDGE_HI && rising) ? DUTY_FULL : bias;
							nxt_close = '0;
							c_new     = (c_upw > {1'b0, t}) ? t : c_upw[POS_W-1:0];
						end else if (down) begin
							nxt_close = (raw < EDGE_LO && falling) ? DUTY_FULL : bias;
							nxt_open  = '0;
							c_new     = (c_dn < t) ? t : c_dn;
						end
						// End stops snap exactly.
						if (t == '0) begin
							c_new = '0;
						end
						if (t == POS_MAX) begin
							c_new = POS_MAX;
						end
						nxt_cur = c_new;
					end
				end
			end
			CMD_TICK: begin
				if (idle_q != MS_SAT) begin
					nxt_idle = idle_q + 16'd1;
				end
				if (lock_q != '0) begin
					nxt_lock = lock_q - 16'd1;
				end
				if (force_q != '0) begin
					nxt_force = force_q - 16'd1;
					if (force_q == 16'd1) begin
						nxt_open  = '0;
						nxt_close = '0;
					end
				end
			end
			CMD_CLOSE: begin
				if (force_q == '0) begin
					nxt_cur   = '0;
					nxt_open  = '0;
					nxt_force = force_ms_q;
					nxt_lock  = lockout_ms_q;
					nxt_close = (force_ms_q != '0) ? DUTY_FULL : '0;
				end
			end
			default: ;
		endcase

		if ((nxt_force == '0) && (nxt_idle > idle_ms_q)) begin
			nxt_open  = '0;
			nxt_close = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			target_q <= '0;
			prev_q   <= '0;
			open_q   <= '0;
			close_q  <= '0;
			idle_q   <= MS_SAT;
			lock_q   <= '0;
			force_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (ctl.apply) begin
				cur_q    <= nxt_cur;
				target_q <= nxt_target;
				prev_q   <= nxt_prev;
				open_q   <= nxt_open;
				close_q  <= nxt_close;
				idle_q   <= nxt_idle;
				lock_q   <= nxt_lock;
				force_q  <= nxt_force;
				rvalid_q <= 1'b1;
			end else if (!result_stall) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			r_open_q   <= nxt_open;
			r_close_q  <= nxt_close;
			r_pos_q    <= nxt_cur;
			r_target_q <= nxt_target;
			r_locked_q <= (nxt_force != '0) || (nxt_lock != '0);
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.out_free = !rvalid_q || !result_stall;

	assign result_valid = rvalid_q;
	assign open_duty    = r_open_q;
	assign close_duty   = r_close_q;
	assign position     = r_pos_q;
	assign target       = r_target_q;
	assign locked       = r_locked_q;

endmodule

>>> sv/vprd_ctrl.sv
// Controller state machine: takes a word, waits on the divider, commits the result.
// Depends on vprd_pkg.
`timescale 1ns / 1ps

module vprd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  vprd_pkg::vprd_status_t sts,
	output vprd_pkg::vprd_cmd_t    ctl
);
	import vprd_pkg::*;

	vprd_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		ctl.load   = 1'b0;
		ctl.apply  = 1'b0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (sts.out_free) begin
					ctl.apply = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

>>> tb/tb_valve_position_ramp_drive_core.sv
// Self-checking testbench for valve_position_ramp_drive_core: random stall and
// gap handshakes, an in-bench valve drive predictor and per-field result checks.
// Depends on vprd_pkg and the valve_position_ramp_drive_core RTL.
`timescale 1ns / 1ps

module tb_valve_position_ramp_drive_core;
	import vprd_pkg::*;

	// The fourth command code has no function; the block must report its state unchanged.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [DUTY_W-1:0] open_d;
		logic [DUTY_W-1:0] close_d;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  tgt;
		logic              lck;
	} drive_word_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [IDX_W-1:0]       cfg_index    = '0;
	logic [CFG_W-1:0]       cfg_data     = '0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	logic [CMD_W-1:0]       cmd          = CMD_TICK;
	logic [SAMPLE_BITS-1:0] pot_sample   = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [DUTY_W-1:0]      open_duty;
	logic [DUTY_W-1:0]      close_duty;
	logic [POS_W-1:0]       position;
	logic [POS_W-1:0]       target;
	logic                   locked;

	// Valve drive state as the block should hold it after every accepted word.
	logic [POS_W-1:0]       valve_pos;
	logic [POS_W-1:0]       valve_tgt;
	logic [SAMPLE_BITS-1:0] last_pot;
	logic [DUTY_W-1:0]      open_lvl;
	logic [DUTY_W-1:0]      close_lvl;
	logic [MS_W-1:0]        idle_ms_seen;
	logic [MS_W-1:0]        lock_left;
	logic [MS_W-1:0]        force_left_ms;

	// Register contents as last written.
	logic [SAMPLE_BITS-1:0] cal_lo;
	logic [SAMPLE_BITS-1:0] cal_hi;
	logic [POS_W-1:0]       ramp_pct;
	logic [POS_W-1:0]       band_pct;
	logic [MS_W-1:0]        idle_limit;
	logic [MS_W-1:0]        lock_len;
	logic [MS_W-1:0]        force_len;

	drive_word_t drive_words_due[$];
	int          fail_count   = 0;
	int          tx_gap_max   = 16;
	int          rx_stall_max = 16;
	int          hold_cycles  = 0;
	int          pot_walk     = 512;

	valve_position_ramp_drive_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.pot_sample   (pot_sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.open_duty    (open_duty),
		.close_duty   (close_duty),
		.position     (position),
		.target       (target),
		.locked       (locked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// A hung handshake or a result that never comes ends the run here.
	initial begin
		#6_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic reset_valve_state();
		valve_pos     = '0;
		valve_tgt     = '0;
		last_pot      = '0;
		open_lvl      = '0;
		close_lvl     = '0;
		idle_ms_seen  = 16'hFFFF;
		lock_left     = '0;
		force_left_ms = '0;
		cal_lo        = 10'd0;
		cal_hi        = 10'd1023;
		ramp_pct      = 7'd5;
		band_pct      = 7'd2;
		idle_limit    = 16'd500;
		lock_len      = 16'd5000;
		force_len     = 16'd2000;
	endtask

	// Applies one word to the valve state and returns the drive word it reports.
	task automatic step_valve_drive(input logic [CMD_W-1:0] c,
			input logic [SAMPLE_BITS-1:0] s, output drive_word_t w);
		int x;
		int raw;
		int goal;
		int cur;
		int diff;
		bit rising;
		bit falling;
		bit move;
		case (c)
			CMD_SAMPLE: begin
				if (force_left_ms == 0 && lock_left == 0) begin
					// Scale the clamped reading to percent of the calibrated span.
					if (cal_hi <= cal_lo) begin
						raw = 0;
					end else begin
						x = int'(s);
						if (x < int'(cal_lo)) x = int'(cal_lo);
						if (x > int'(cal_hi)) x = int'(cal_hi);
						raw = (x - int'(cal_lo)) * 100 / (int'(cal_hi) - int'(cal_lo));
					end
					rising  = s > last_pot;
					falling = s < last_pot;
					if (raw < 20) goal = 0;
					else if (raw > 80) goal = 100;
					else goal = (raw - 20) * 100 / 60;
					valve_tgt = POS_W'(goal);
					cur  = int'(valve_pos);
					diff = (goal > cur) ? goal - cur : cur - goal;
					move = diff > int'(band_pct) || (goal == 0 && cur > 0) ||
						(goal == 100 && cur < 100);
					if (move) begin
						idle_ms_seen = '0;
						if (goal > cur) begin
							open_lvl  = DUTY_W'((raw > 80 && rising) ? 255 : diff + 50);
							close_lvl = '0;
							cur = cur + int'(ramp_pct);
							if (cur > goal) cur = goal;
						end else if (goal < cur) begin
							close_lvl = DUTY_W'((raw < 20 && falling) ? 255 : diff + 50);
							open_lvl  = '0;
							cur = (cur > int'(ramp_pct)) ? cur - int'(ramp_pct) : 0;
							if (cur < goal) cur = goal;
						end
						// End stops are reached in one move whatever the step.
						if (goal == 0) cur = 0;
						if (goal == 100) cur = 100;
						valve_pos = POS_W'(cur);
					end
					last_pot = s;
				end
			end
			CMD_TICK: begin
				if (idle_ms_seen != 16'hFFFF) idle_ms_seen = idle_ms_seen + 16'd1;
				if (lock_left != 0) lock_left = lock_left - 16'd1;
				if (force_left_ms != 0) begin
					force_left_ms = force_left_ms - 16'd1;
					if (force_left_ms == 0) begin
						open_lvl  = '0;
						close_lvl = '0;
					end
				end
			end
			CMD_CLOSE: begin
				if (force_left_ms == 0) begin
					valve_pos     = '0;
					open_lvl      = '0;
					force_left_ms = force_len;
					lock_left     = lock_len;
					close_lvl     = (force_len != 0) ? 8'd255 : 8'd0;
				end
			end
			default: begin
			end
		endcase
		if (force_left_ms == 0 && idle_ms_seen > idle_limit) begin
			open_lvl  = '0;
			close_lvl = '0;
		end
		w.open_d  = open_lvl;
		w.close_d = close_lvl;
		w.pos     = valve_pos;
		w.tgt     = valve_tgt;
		w.lck     = (force_left_ms != 0 || lock_left != 0);
	endtask

	// Offers one word after a random gap and holds it until the block takes it.
	task automatic send_word(input logic [CMD_W-1:0] c, input logic [SAMPLE_BITS-1:0] s);
		int gap;
		bit taken;
		drive_word_t w;
		gap = $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		pot_sample <= s;
		do begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end while (!taken);
		step_valve_drive(c, s, w);
		drive_words_due.push_back(w);
	endtask

	// Every word yields one result, so an empty queue plus the pipeline depth means idle.
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (drive_words_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CAL_MIN:   cal_lo     = SAMPLE_BITS'(val);
			REG_CAL_MAX:   cal_hi     = SAMPLE_BITS'(val);
			REG_RAMP_STEP: ramp_pct   = POS_W'(val);
			REG_DEADBAND:  band_pct   = POS_W'(val);
			REG_IDLE_MS:   idle_limit = MS_W'(val);
			REG_LOCKOUT:   lock_len   = MS_W'(val);
			REG_FORCE_MS:  force_len  = MS_W'(val);
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input int cmin, input int cmax, input int step, input int band,
			input int idle, input int lock, input int frc);
		wait_drained();
		write_reg(REG_CAL_MIN, cmin);
		write_reg(REG_CAL_MAX, cmax);
		write_reg(REG_RAMP_STEP, step);
		write_reg(REG_DEADBAND, band);
		write_reg(REG_IDLE_MS, idle);
		write_reg(REG_LOCKOUT, lock);
		write_reg(REG_FORCE_MS, frc);
		pot_walk = (cmin + cmax) / 2;
	endtask

	// Pot readings mostly wander like a turned knob, with jumps and end values mixed in.
	function automatic logic [SAMPLE_BITS-1:0] pick_pot();
		int r;
		int v;
		r = $urandom_range(99, 0);
		if (r < 20) begin
			v = $urandom_range(1023, 0);
		end else if (r < 30) begin
			case ($urandom_range(3, 0))
				0: v = 0;
				1: v = 1023;
				2: v = int'(cal_lo);
				default: v = int'(cal_hi);
			endcase
		end else begin
			v = pot_walk + $urandom_range(80, 0) - 40;
		end
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		pot_walk = v;
		return SAMPLE_BITS'(v);
	endfunction

	// Picks a word kind; while samples are locked out, ticks dominate so the lockout ends.
	function automatic logic [CMD_W-1:0] pick_cmd();
		int r;
		r = $urandom_range(199, 0);
		if (force_left_ms != 0 || lock_left != 0) begin
			if (r < 140) return CMD_TICK;
			if (r < 190) return CMD_SAMPLE;
			if (r < 196) return CMD_CLOSE;
			return CMD_SPARE;
		end
		if (r < 120) return CMD_SAMPLE;
		if (r < 184) return CMD_TICK;
		if (r < 187) return CMD_CLOSE;
		return CMD_SPARE;
	endfunction

	// Register defaults from reset: saturated idle counter, unused command, end stops.
	task automatic test_reset_defaults();
		send_word(CMD_TICK, 10'd0);
		send_word(CMD_SPARE, 10'h3FF);
		send_word(CMD_SAMPLE, 10'h3FF);
		send_word(CMD_SAMPLE, 10'd0);
		send_word(CMD_SAMPLE, 10'd819);
	endtask

	// A span that is empty or inverted scales every reading to zero.
	task automatic test_bad_calibration();
		set_config(600, 600, 5, 2, 500, 0, 0);
		send_word(CMD_SAMPLE, 10'd700);
		set_config(1023, 0, 5, 2, 500, 0, 0);
		send_word(CMD_SAMPLE, 10'd1023);
	endtask

	// Close press, presses and samples ignored during the drive and the lockout,
	// the duty clear when the drive ends, and a press with no drive time at all.
	task automatic test_close_button();
		set_config(0, 1023, 10, 2, 40, 4, 2);
		send_word(CMD_SAMPLE, 10'd1023);
		send_word(CMD_CLOSE, 10'd0);
		send_word(CMD_SAMPLE, 10'd512);
		send_word(CMD_CLOSE, 10'd0);
		repeat (4) send_word(CMD_TICK, 10'd0);
		send_word(CMD_SAMPLE, 10'd1023);
		set_config(0, 1023, 10, 2, 40, 1, 0);
		send_word(CMD_CLOSE, 10'd0);
		send_word(CMD_TICK, 10'd0);
	endtask

	// With no ramp step only the end-stop snap moves the valve; a zero idle time
	// clears the duties on the first tick after a move.
	task automatic test_zero_step_idle();
		set_config(0, 1023, 0, 0, 0, 0, 0);
		send_word(CMD_SAMPLE, 10'd511);
		send_word(CMD_TICK, 10'd0);
		send_word(CMD_SAMPLE, 10'd1023);
	endtask

	task automatic test_random_phases();
		int ph;
		int live;
		int cmin;
		int cmax;
		logic [CMD_W-1:0] c;
		bit ignored;
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin tx_gap_max = 16; rx_stall_max = 16; end
				1: begin tx_gap_max = 0;  rx_stall_max = 0;  end
				2: begin tx_gap_max = 16; rx_stall_max = 0;  end
				default: begin tx_gap_max = 0; rx_stall_max = 16; end
			endcase
			case (ph)
				0: set_config(0, 1023, 1, 0, 0, 0, 0);
				1: set_config(0, 1023, 100, 100, 65535, 20, 10);
				2: set_config(512, 513, 7, 3, 30, 8, 4);
				default: begin
					cmin = $urandom_range(1000, 0);
					cmax = $urandom_range(1023, cmin + 1);
					if ($urandom_range(7, 0) == 0) cmax = $urandom_range(cmin, 0);
					set_config(cmin, cmax,
						($urandom_range(9, 0) == 0) ? 0 : $urandom_range(100, 1),
						($urandom_range(3, 0) == 0) ? $urandom_range(100, 0)
							: $urandom_range(10, 0),
						$urandom_range(60, 0), $urandom_range(20, 0),
						$urandom_range(10, 0));
				end
			endcase
			live = 0;
			while (live < 150) begin
				c = pick_cmd();
				ignored = (c == CMD_SPARE) || (c == CMD_CLOSE && force_left_ms != 0) ||
					(c == CMD_SAMPLE && (force_left_ms != 0 || lock_left != 0));
				send_word(c, (c == CMD_SAMPLE) ? pick_pot() : 10'($urandom_range(1023, 0)));
				if (!ignored) live++;
			end
		end
	endtask

	// The consumer holds off for a long stretch while words keep coming back to
	// back, so the result register and the pipeline fill and the input stalls.
	task automatic test_backpressure();
		int k;
		logic [CMD_W-1:0] c;
		wait_drained();
		tx_gap_max   = 0;
		rx_stall_max = 4;
		hold_cycles  = 300;
		for (k = 0; k < 60; k++) begin
			c = pick_cmd();
			send_word(c, pick_pot());
		end
		wait_drained();
		tx_gap_max   = 16;
		rx_stall_max = 16;
	endtask

	// Largest timer values: the drive and lockout outlast the run and idle never clears.
	task automatic test_long_timers();
		set_config(0, 1023, 100, 0, 65535, 65535, 65535);
		send_word(CMD_SAMPLE, 10'd1023);
		send_word(CMD_CLOSE, 10'd0);
		repeat (3) send_word(CMD_TICK, 10'd0);
		send_word(CMD_SAMPLE, 10'd300);
		send_word(CMD_CLOSE, 10'd0);
		send_word(CMD_SPARE, 10'd0);
	endtask

	// Result side: random stall before each word, an optional long hold, and a
	// field-by-field compare against the oldest pending prediction.
	initial begin
		int n;
		bit seen;
		drive_word_t got;
		drive_word_t want;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			n = $urandom_range(rx_stall_max, 0);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do begin
				@(negedge clk);
				seen = result_valid;
				got  = {open_duty, close_duty, position, target, locked};
				@(posedge clk);
			end while (!seen);
			if (drive_words_due.size() == 0) begin
				$error("result word arrived with no prediction pending");
				fail_count++;
			end else begin
				want = drive_words_due.pop_front();
				if (got.open_d !== want.open_d) begin
					$error("open_duty: expected %0d, got %0d", want.open_d, got.open_d);
					fail_count++;
				end
				if (got.close_d !== want.close_d) begin
					$error("close_duty: expected %0d, got %0d", want.close_d, got.close_d);
					fail_count++;
				end
				if (got.pos !== want.pos) begin
					$error("position: expected %0d, got %0d", want.pos, got.pos);
					fail_count++;
				end
				if (got.tgt !== want.tgt) begin
					$error("target: expected %0d, got %0d", want.tgt, got.tgt);
					fail_count++;
				end
				if (got.lck !== want.lck) begin
					$error("locked: expected %0d, got %0d", want.lck, got.lck);
					fail_count++;
				end
			end
		end
	end

	initial begin
		reset_valve_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_bad_calibration();
		test_close_button();
		test_zero_step_idle();
		test_random_phases();
		test_backpressure();
		test_long_timers();
		wait_drained();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/vprd_pkg.sv
sv/vprd_div.sv
sv/vprd_dp.sv
sv/vprd_ctrl.sv
sv/valve_position_ramp_drive_core.sv
tb/tb_valve_position_ramp_drive_core.sv
